/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL. They vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RSD_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("assertion failed");
`define RSD_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define RSD_ASSERT(lbl, clk, rstn, prop)
`define RSD_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif
`endif

/* rtl/rsd_pkg.sv */
package rsd_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int QUEUE_DEPTH_DEF = 2;
	localparam logic [31:0] THRESH_RESET = 32'd43;
	localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

	// One request after the front end: direction, u = B - A and w = O - A.
	typedef struct packed {
		logic [2:0][31:0] dir;
		logic [2:0][32:0] u;
		logic [2:0][32:0] w;
	} item_t;

	function automatic logic [63:0] sx32(input logic [31:0] x);
		return {{32{x[31]}}, x};
	endfunction

	function automatic logic [63:0] sx33(input logic [32:0] x);
		return {{31{x[32]}}, x};
	endfunction

	function automatic logic [63:0] sadd(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] s;
		s = a + b;
		if (!a[63] && !b[63] && s[63]) return S64_MAX;
		if (a[63] && b[63] && !s[63]) return S64_MIN;
		return s;
	endfunction

	function automatic logic [63:0] ssub(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] d;
		d = a - b;
		if (!a[63] && b[63] && d[63]) return S64_MAX;
		if (a[63] && !b[63] && !d[63]) return S64_MIN;
		return d;
	endfunction

	function automatic logic [63:0] from_mag(input logic neg, input logic [63:0] mag);
		if (!neg) return mag[63] ? S64_MAX : mag;
		return mag[63] ? S64_MIN : (64'd0 - mag);
	endfunction

endpackage

/* rtl/rsd_mulq.sv */
module rsd_mulq #(
	parameter int FRAC_BITS = rsd_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] y
);

	logic [63:0] ma, mb;
	logic [63:0] ll_s1, lh_s1, hl_s1, hh_s1;
	logic        neg_s1;
	logic [127:0] prod;
	logic [63:0] y_s2;

	assign ma = a[63] ? (64'd0 - a) : a;
	assign mb = b[63] ? (64'd0 - b) : b;

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1  <= ma[31:0] * mb[31:0];
			lh_s1  <= ma[31:0] * mb[63:32];
			hl_s1  <= ma[63:32] * mb[31:0];
			hh_s1  <= ma[63:32] * mb[63:32];
			neg_s1 <= a[63] ^ b[63];
		end
	end

	assign prod = {hh_s1, 64'd0} + {32'd0, lh_s1, 32'd0} + {32'd0, hl_s1, 32'd0}
		+ {64'd0, ll_s1};

	always_ff @(posedge clk) begin
		if (en) begin
			if (|prod[127:64+FRAC_BITS])
				y_s2 <= neg_s1 ? rsd_pkg::S64_MIN : rsd_pkg::S64_MAX;
			else
				y_s2 <= rsd_pkg::from_mag(neg_s1, prod[63+FRAC_BITS:FRAC_BITS]);
		end
	end

	assign y = y_s2;

endmodule

/* rtl/rsd_front.sv */
module rsd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic signed [31:0]  ray_origin_x,
	input  logic signed [31:0]  ray_origin_y,
	input  logic signed [31:0]  ray_origin_z,
	input  logic signed [31:0]  ray_dir_x,
	input  logic signed [31:0]  ray_dir_y,
	input  logic signed [31:0]  ray_dir_z,
	input  logic signed [31:0]  seg_a_x,
	input  logic signed [31:0]  seg_a_y,
	input  logic signed [31:0]  seg_a_z,
	input  logic signed [31:0]  seg_b_x,
	input  logic signed [31:0]  seg_b_y,
	input  logic signed [31:0]  seg_b_z,
	output logic                q_push,
	output rsd_pkg::item_t      q_data,
	input  logic                q_full
);

	rsd_pkg::item_t item_in, item_s1;
	logic           v_s1;

	always_comb begin
		item_in.dir[0] = ray_dir_x;
		item_in.dir[1] = ray_dir_y;
		item_in.dir[2] = ray_dir_z;
		item_in.u[0] = {seg_b_x[31], seg_b_x} - {seg_a_x[31], seg_a_x};
		item_in.u[1] = {seg_b_y[31], seg_b_y} - {seg_a_y[31], seg_a_y};
		item_in.u[2] = {seg_b_z[31], seg_b_z} - {seg_a_z[31], seg_a_z};
		item_in.w[0] = {ray_origin_x[31], ray_origin_x} - {seg_a_x[31], seg_a_x};
		item_in.w[1] = {ray_origin_y[31], ray_origin_y} - {seg_a_y[31], seg_a_y};
		item_in.w[2] = {ray_origin_z[31], ray_origin_z} - {seg_a_z[31], seg_a_z};
	end

	assign full = v_s1 && q_full;
	assign q_push = v_s1 && !q_full;
	assign q_data = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!full) begin
			v_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (!full && push) begin
			item_s1 <= item_in;
		end
	end

endmodule

/* rtl/rsd_fifo.sv */
module rsd_fifo #(
	parameter int DEPTH = rsd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  rsd_pkg::item_t wr_data,
	output logic           full,
	input  logic           rd_en,
	output rsd_pkg::item_t rd_data,
	output logic           empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	rsd_pkg::item_t  mem [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign rd_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/rsd_back.sv */
module rsd_back #(
	parameter int FRAC_BITS = rsd_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [31:0]        thresh,
	input  rsd_pkg::item_t     head,
	input  logic               head_valid,
	output logic               head_pop,
	input  logic               res_pop,
	output logic               res_empty,
	output logic [30:0]        closest_distance,
	output logic signed [31:0] ray_param,
	output logic               parallel_flag
);

	localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;
	localparam logic [1:0] SEL_ZERO = 2'd0;
	localparam logic [1:0] SEL_ONE = 2'd1;
	localparam logic [1:0] SEL_DIV = 2'd2;
	localparam int NSQ = 32;

	typedef struct packed {
		rsd_pkg::item_t it;
		logic [63:0]    b, c, d, e, denom, num, s, t, rem, q;
		logic           par;
		logic [1:0]     sel;
	} ctx_t;

	typedef struct packed {
		logic [63:0] n;
		logic [63:0] res;
		logic        huge;
		logic [63:0] t;
		logic        par;
	} rt_t;

	function automatic ctx_t div_step(input ctx_t c);
		logic [64:0] r2;
		ctx_t o;
		o = c;
		r2 = {c.rem, 1'b0};
		o.q = {c.q[62:0], 1'b0};
		if (r2 >= {1'b0, c.denom}) begin
			r2 = r2 - {1'b0, c.denom};
			o.q[0] = 1'b1;
		end
		o.rem = r2[63:0];
		return o;
	endfunction

	logic en;
	logic out_v_q;

	// The whole pipeline moves together; it holds only while a result waits.
	assign en = !out_v_q || res_pop;
	assign head_pop = en && head_valid;
	assign res_empty = !out_v_q;

	// Dot products: b = D.u, c = u.u, d = D.w, e = u.w.
	logic [2:0][63:0] pb, pc, pd, pe;
	for (genvar k = 0; k < 3; k++) begin : g_dot
		rsd_mulq #(.FRAC_BITS(FRAC_BITS)) u_pb (.clk(clk), .en(en),
			.a(rsd_pkg::sx32(head.dir[k])), .b(rsd_pkg::sx33(head.u[k])), .y(pb[k]));
		rsd_mulq #(.FRAC_BITS(FRAC_BITS)) u_pc (.clk(clk), .en(en),
			.a(rsd_pkg::sx33(head.u[k])), .b(rsd_pkg::sx33(head.u[k])), .y(pc[k]));
		rsd_mulq #(.FRAC_BITS(FRAC_BITS)) u_pd (.clk(clk), .en(en),
			.a(rsd_pkg::sx32(head.dir[k])), .b(rsd_pkg::sx33(head.w[k])), .y(pd[k]));
		rsd_mulq #(.FRAC_BITS(FRAC_BITS)) u_pe (.clk(clk), .en(en),
			.a(rsd_pkg::sx33(head.u[k])), .b(rsd_pkg::sx33(head.w[k])), .y(pe[k]));
	end

	ctx_t c_s1, c_s2, c_s3, c_s4, c_s5, c_s6, c_s8, c_s9, c_s10, c_s11, c_s12, c_s13;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s8, v_s9, v_s10, v_s11, v_s12, v_s13;
	ctx_t div_s [FRAC_BITS+1];
	logic div_v_s [FRAC_BITS+1];
	ctx_t n_s1, n_s3, n_s6, n_div0, n_s8, n_s11;

	always_comb begin
		n_s1 = '0;
		n_s1.it = head;
		n_s3 = c_s2;
		n_s3.b = rsd_pkg::sadd(rsd_pkg::sadd(pb[0], pb[1]), pb[2]);
		n_s3.c = rsd_pkg::sadd(rsd_pkg::sadd(pc[0], pc[1]), pc[2]);
		n_s3.d = rsd_pkg::sadd(rsd_pkg::sadd(pd[0], pd[1]), pd[2]);
		n_s3.e = rsd_pkg::sadd(rsd_pkg::sadd(pe[0], pe[1]), pe[2]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1 <= n_s1;
			c_s2 <= c_s1;
			c_s3 <= n_s3;
			c_s4 <= c_s3;
			c_s5 <= c_s4;
		end
	end

	logic [63:0] bb, bd;
	rsd_mulq #(.FRAC_BITS(FRAC_BITS)) u_bb (.clk(clk), .en(en),
		.a(c_s3.b), .b(c_s3.b), .y(bb));
	rsd_mulq #(.FRAC_BITS(FRAC_BITS)) u_bd (.clk(clk), .en(en),
		.a(c_s3.b), .b(c_s3.d), .y(bd));

	logic [31:0] denom_sh;
	assign denom_sh = {c_s6.denom[FRAC_BITS-1:0], {(32-FRAC_BITS){1'b0}}};

	always_comb begin
		n_s6 = c_s5;
		n_s6.denom = rsd_pkg::ssub(c_s5.c, bb);
		n_s6.num = rsd_pkg::ssub(c_s5.e, bd);

		// Classify and seed the divider with the numerator.
		n_div0 = c_s6;
		if (c_s6.denom[63])
			n_div0.par = 1'b1;
		else if (c_s6.denom >= ONE)
			n_div0.par = 1'b0;
		else
			n_div0.par = denom_sh < thresh;
		if (c_s6.num[63] || c_s6.num == '0)
			n_div0.sel = SEL_ZERO;
		else if ($signed(c_s6.num) >= $signed(c_s6.denom))
			n_div0.sel = SEL_ONE;
		else
			n_div0.sel = SEL_DIV;
		n_div0.rem = c_s6.num;
		n_div0.q = '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s6 <= n_s6;
			div_s[0] <= n_div0;
		end
	end

	for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_div
		always_ff @(posedge clk) begin
			if (en) begin
				div_s[k] <= div_step(div_s[k-1]);
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_s[k] <= 1'b0;
			end else if (en) begin
				div_v_s[k] <= div_v_s[k-1];
			end
		end
	end

	logic [63:0] bs;
	rsd_mulq #(.FRAC_BITS(FRAC_BITS)) u_bs (.clk(clk), .en(en),
		.a(c_s8.b), .b(c_s8.s), .y(bs));

	logic [2:0][63:0] dt, us;
	for (genvar k = 0; k < 3; k++) begin : g_pt
		rsd_mulq #(.FRAC_BITS(FRAC_BITS)) u_dt (.clk(clk), .en(en),
			.a(rsd_pkg::sx32(c_s11.it.dir[k])), .b(c_s11.t), .y(dt[k]));
		rsd_mulq #(.FRAC_BITS(FRAC_BITS)) u_us (.clk(clk), .en(en),
			.a(rsd_pkg::sx33(c_s11.it.u[k])), .b(c_s11.s), .y(us[k]));
	end

	always_comb begin
		n_s8 = div_s[FRAC_BITS];
		if (div_s[FRAC_BITS].par || div_s[FRAC_BITS].sel == SEL_ZERO)
			n_s8.s = '0;
		else if (div_s[FRAC_BITS].sel == SEL_ONE)
			n_s8.s = ONE;
		else
			n_s8.s = div_s[FRAC_BITS].q;
		n_s11 = c_s10;
		n_s11.t = c_s10.par ? rsd_pkg::ssub(64'd0, c_s10.d)
			: rsd_pkg::ssub(bs, c_s10.d);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s8 <= n_s8;
			c_s9 <= c_s8;
			c_s10 <= c_s9;
			c_s11 <= n_s11;
			c_s12 <= c_s11;
			c_s13 <= c_s12;
		end
	end

	// Difference vector, its magnitude and the sum of squares.
	logic [2:0][63:0] diff_s14, neg_s14;
	logic [63:0] t_s14, t_s15, t_s16;
	logic        par_s14, par_s15, par_s16;
	logic        huge_s15, huge_s16;
	logic [2:0][30:0] m_s15;
	logic [2:0][61:0] sq_s16;
	logic        v_s14, v_s15, v_s16;
	rt_t         rt_s [NSQ+1];
	logic        rt_v_s [NSQ+1];

	for (genvar k = 0; k < 3; k++) begin : g_neg
		assign neg_s14[k] = 64'd0 - diff_s14[k];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				diff_s14[k] <= rsd_pkg::ssub(
					rsd_pkg::sadd(rsd_pkg::sx33(c_s13.it.w[k]), dt[k]), us[k]);
				m_s15[k] <= diff_s14[k][63] ? neg_s14[k][30:0] : diff_s14[k][30:0];
				sq_s16[k] <= m_s15[k] * m_s15[k];
			end
			t_s14 <= c_s13.t;
			par_s14 <= c_s13.par;
			huge_s15 <= ($signed(diff_s14[0]) > 64'sd2147483647)
				|| ($signed(diff_s14[0]) < -64'sd2147483647)
				|| ($signed(diff_s14[1]) > 64'sd2147483647)
				|| ($signed(diff_s14[1]) < -64'sd2147483647)
				|| ($signed(diff_s14[2]) > 64'sd2147483647)
				|| ($signed(diff_s14[2]) < -64'sd2147483647);
			t_s15 <= t_s14;
			par_s15 <= par_s14;
			huge_s16 <= huge_s15;
			t_s16 <= t_s15;
			par_s16 <= par_s15;
			rt_s[0].n <= {2'b00, sq_s16[0]} + {2'b00, sq_s16[1]} + {2'b00, sq_s16[2]};
			rt_s[0].res <= '0;
			rt_s[0].huge <= huge_s16;
			rt_s[0].t <= t_s16;
			rt_s[0].par <= par_s16;
		end
	end

	// Integer square root, one result bit per stage.
	for (genvar k = 1; k <= NSQ; k++) begin : g_sqrt
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * (k - 1));
		logic [63:0] trial;
		rt_t         nxt;
		assign trial = rt_s[k-1].res + BIT;
		always_comb begin
			nxt = rt_s[k-1];
			if (rt_s[k-1].n >= trial) begin
				nxt.n = rt_s[k-1].n - trial;
				nxt.res = (rt_s[k-1].res >> 1) + BIT;
			end else begin
				nxt.res = rt_s[k-1].res >> 1;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rt_s[k] <= nxt;
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v_s[k] <= 1'b0;
			end else if (en) begin
				rt_v_s[k] <= rt_v_s[k-1];
			end
		end
	end

	logic [30:0] dist_q;
	logic [31:0] t_q;
	logic        par_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (rt_s[NSQ].huge || rt_s[NSQ].res > 64'h7FFF_FFFF)
				dist_q <= '1;
			else
				dist_q <= rt_s[NSQ].res[30:0];
			if ($signed(rt_s[NSQ].t) > 64'sd2147483647)
				t_q <= 32'h7FFF_FFFF;
			else if ($signed(rt_s[NSQ].t) < -64'sd2147483648)
				t_q <= 32'h8000_0000;
			else
				t_q <= rt_s[NSQ].t[31:0];
			par_q <= rt_s[NSQ].par;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; div_v_s[0] <= 1'b0;
			v_s8 <= 1'b0; v_s9 <= 1'b0; v_s10 <= 1'b0; v_s11 <= 1'b0;
			v_s12 <= 1'b0; v_s13 <= 1'b0; v_s14 <= 1'b0; v_s15 <= 1'b0;
			v_s16 <= 1'b0; rt_v_s[0] <= 1'b0; out_v_q <= 1'b0;
		end else if (en) begin
			v_s1 <= head_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			div_v_s[0] <= v_s6;
			v_s8 <= div_v_s[FRAC_BITS];
			v_s9 <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
			v_s15 <= v_s14;
			v_s16 <= v_s15;
			rt_v_s[0] <= v_s16;
			out_v_q <= rt_v_s[NSQ];
		end
	end

	assign closest_distance = dist_q;
	assign ray_param = t_q;
	assign parallel_flag = par_q;

endmodule

/* rtl/ray_segment_distance_core.sv */
// Closest distance between a ray's line and a 3D segment, in signed fixed
// point with COORD_FRAC_BITS fraction bits. One request is taken per clock and
// one result leaves per clock while results are popped and the queue has room. The
// depth of the back pipeline is set by the one-bit-per-stage divider for the
// segment parameter and the 32-stage square root; a request first passes the
// front stage and queue. The back pipeline holds as a whole while a result is not
// popped; the small queue between front and back absorbs that stall. The
// parallel threshold register may only be written while the block is idle.
`include "assert_macros.svh"

module ray_segment_distance_core #(
	parameter int COORD_FRAC_BITS = rsd_pkg::FRAC_BITS_DEF,
	parameter int QUEUE_DEPTH = rsd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [31:0]        cfg_wr_data,
	input  logic               push,
	output logic               full,
	input  logic signed [31:0] ray_origin_x,
	input  logic signed [31:0] ray_origin_y,
	input  logic signed [31:0] ray_origin_z,
	input  logic signed [31:0] ray_dir_x,
	input  logic signed [31:0] ray_dir_y,
	input  logic signed [31:0] ray_dir_z,
	input  logic signed [31:0] seg_a_x,
	input  logic signed [31:0] seg_a_y,
	input  logic signed [31:0] seg_a_z,
	input  logic signed [31:0] seg_b_x,
	input  logic signed [31:0] seg_b_y,
	input  logic signed [31:0] seg_b_z,
	output logic               empty,
	input  logic               pop,
	output logic [30:0]        closest_distance,
	output logic signed [31:0] ray_param,
	output logic               parallel_flag
);

	logic [31:0]    thresh_q;
	logic           f_push, f_full, f_empty, b_pop;
	rsd_pkg::item_t f_wdata, f_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= rsd_pkg::THRESH_RESET;
		end else if (cfg_wr_en) begin
			thresh_q <= cfg_wr_data;
		end
	end

	rsd_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.ray_origin_x(ray_origin_x), .ray_origin_y(ray_origin_y),
		.ray_origin_z(ray_origin_z), .ray_dir_x(ray_dir_x), .ray_dir_y(ray_dir_y),
		.ray_dir_z(ray_dir_z), .seg_a_x(seg_a_x), .seg_a_y(seg_a_y),
		.seg_a_z(seg_a_z), .seg_b_x(seg_b_x), .seg_b_y(seg_b_y), .seg_b_z(seg_b_z),
		.q_push(f_push), .q_data(f_wdata), .q_full(f_full)
	);

	rsd_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk(clk), .arst_n(arst_n), .wr_en(f_push), .wr_data(f_wdata),
		.full(f_full), .rd_en(b_pop), .rd_data(f_rdata), .empty(f_empty)
	);

	rsd_back #(.FRAC_BITS(COORD_FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .thresh(thresh_q), .head(f_rdata),
		.head_valid(!f_empty), .head_pop(b_pop), .res_pop(pop), .res_empty(empty),
		.closest_distance(closest_distance), .ray_param(ray_param),
		.parallel_flag(parallel_flag)
	);

	`RSD_ASSERT(a_no_push_full, clk, arst_n, f_push |-> !f_full)
	`RSD_ASSERT(a_no_pop_empty, clk, arst_n, b_pop |-> !f_empty)
	`RSD_ASSERT_NEXT(a_push_lands, clk, arst_n, f_push && !b_pop, !f_empty)

endmodule

/* test/tb_top.sv */
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB = 16;
	localparam logic signed [63:0] ONE = 64'sd1 <<< FB;
	localparam logic signed [63:0] MAX64 = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] MIN64 = 64'sh8000_0000_0000_0000;

	typedef struct {
		logic signed [31:0] org[3];
		logic signed [31:0] dir[3];
		logic signed [31:0] pa[3];
		logic signed [31:0] pb[3];
	} query_t;

	typedef struct {
		logic [30:0] distance;
		logic signed [31:0] tpar;
		logic par;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [31:0] cfg_wr_data = '0;
	logic push = 1'b0;
	logic full;
	logic signed [31:0] ray_origin_x = '0, ray_origin_y = '0, ray_origin_z = '0;
	logic signed [31:0] ray_dir_x = '0, ray_dir_y = '0, ray_dir_z = '0;
	logic signed [31:0] seg_a_x = '0, seg_a_y = '0, seg_a_z = '0;
	logic signed [31:0] seg_b_x = '0, seg_b_y = '0, seg_b_z = '0;
	logic empty;
	logic pop = 1'b0;
	logic [30:0] closest_distance;
	logic signed [31:0] ray_param;
	logic parallel_flag;

	logic [31:0] threshold;
	answer_t pending_answers[$];
	int errors = 0;
	int sent = 0;
	int checked = 0;
	int parallel_seen = 0;
	bit rx_idle_on = 1'b1;
	int rx_hold = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	ray_segment_distance_core uut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.push(push), .full(full),
		.ray_origin_x(ray_origin_x), .ray_origin_y(ray_origin_y),
		.ray_origin_z(ray_origin_z),
		.ray_dir_x(ray_dir_x), .ray_dir_y(ray_dir_y), .ray_dir_z(ray_dir_z),
		.seg_a_x(seg_a_x), .seg_a_y(seg_a_y), .seg_a_z(seg_a_z),
		.seg_b_x(seg_b_x), .seg_b_y(seg_b_y), .seg_b_z(seg_b_z),
		.empty(empty), .pop(pop), .closest_distance(closest_distance),
		.ray_param(ray_param), .parallel_flag(parallel_flag)
	);

	function automatic logic signed [63:0] add_sat(logic signed [63:0] a, logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > 65'(MAX64)) return MAX64;
		if (s < 65'(MIN64)) return MIN64;
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] sub_sat(logic signed [63:0] a, logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) - 65'(b);
		if (s > 65'(MAX64)) return MAX64;
		if (s < 65'(MIN64)) return MIN64;
		return s[63:0];
	endfunction

	// Exact product truncated toward zero, then saturated.
	function automatic logic signed [63:0] fx_mul(logic signed [63:0] a, logic signed [63:0] b);
		logic neg;
		logic [63:0] ma, mb;
		logic [127:0] p;
		neg = (a < 0) != (b < 0);
		ma = a < 0 ? -a : a;
		mb = b < 0 ? -b : b;
		p = {64'd0, ma} * {64'd0, mb};
		p = p >> FB;
		if (p[127:64] != 0) return neg ? MIN64 : MAX64;
		if (!neg) return p[63] ? MAX64 : p[63:0];
		return p[63] ? MIN64 : -$signed(p[63:0]);
	endfunction

	function automatic logic signed [63:0] dot(logic signed [63:0] p[3], logic signed [63:0] q[3]);
		return add_sat(add_sat(fx_mul(p[0], q[0]), fx_mul(p[1], q[1])), fx_mul(p[2], q[2]));
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] n);
		logic [63:0] r;
		r = 0;
		for (int k = 31; k >= 0; k--)
			if ((r | (64'd1 << k)) * (r | (64'd1 << k)) <= n) r |= 64'd1 << k;
		return r;
	endfunction

	function automatic answer_t closest_approach(query_t q);
		logic signed [63:0] dv[3], uv[3], wv[3], df[3];
		logic signed [63:0] b, c, d, e, den, s, t, num;
		logic [63:0] sum, m, dist_v;
		logic par, huge;
		answer_t r;
		for (int k = 0; k < 3; k++) begin
			dv[k] = q.dir[k];
			uv[k] = 64'(q.pb[k]) - 64'(q.pa[k]);
			wv[k] = 64'(q.org[k]) - 64'(q.pa[k]);
		end
		b = dot(dv, uv);
		c = dot(uv, uv);
		d = dot(dv, wv);
		e = dot(uv, wv);
		den = sub_sat(c, fx_mul(b, b));
		if (den < 0) par = 1'b1;
		else if (den >= ONE) par = 1'b0;
		else par = (64'(den) << (32 - FB)) < {32'd0, threshold};
		if (par) begin
			s = 0;
			t = sub_sat(0, d);
		end else begin
			num = sub_sat(e, fx_mul(b, d));
			if (num <= 0) s = 0;
			else if (num >= den) s = ONE;
			else s = 64'((128'(num) << FB) / 128'(den));
			t = sub_sat(fx_mul(b, s), d);
		end
		huge = 1'b0;
		sum = 0;
		for (int k = 0; k < 3; k++) begin
			df[k] = sub_sat(add_sat(wv[k], fx_mul(dv[k], t)), fx_mul(uv[k], s));
			if (df[k] >= (64'sd1 <<< 31) || df[k] <= -(64'sd1 <<< 31)) huge = 1'b1;
		end
		if (huge) dist_v = 64'h7FFF_FFFF;
		else begin
			for (int k = 0; k < 3; k++) begin
				m = df[k] < 0 ? -df[k] : df[k];
				sum += m * m;
			end
			dist_v = int_sqrt(sum);
			if (dist_v > 64'h7FFF_FFFF) dist_v = 64'h7FFF_FFFF;
		end
		if (t > 64'sd2147483647) t = 64'sd2147483647;
		if (t < -64'sd2147483648) t = -64'sd2147483648;
		r.distance = dist_v[30:0];
		r.tpar = t[31:0];
		r.par = par;
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		$display("tb: mismatch on %s at %0t: got %0d, expected %0d", what, $realtime, got, want);
	endtask

	// The request stays on the ports until the next one replaces it or the queue drains.
	task automatic send_query(query_t q, bit gaps);
		if (gaps && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		{ray_origin_x, ray_origin_y, ray_origin_z} = {q.org[0], q.org[1], q.org[2]};
		{ray_dir_x, ray_dir_y, ray_dir_z} = {q.dir[0], q.dir[1], q.dir[2]};
		{seg_a_x, seg_a_y, seg_a_z} = {q.pa[0], q.pa[1], q.pa[2]};
		{seg_b_x, seg_b_y, seg_b_z} = {q.pb[0], q.pb[1], q.pb[2]};
		push <= 1'b1;
		do @(posedge clk); while (full);
		pending_answers.push_back(closest_approach(q));
		sent++;
		@(negedge clk);
	endtask

	// Receiver side: random pop bursts, plus a long hold when requested.
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			rx_hold--;
			pop <= 1'b0;
		end else if (rx_idle_on && $urandom_range(0, 3) == 0)
			pop <= 1'b0;
		else
			pop <= 1'b1;
	end

	always @(posedge clk) begin
		answer_t want;
		if (arst_n && pop && !empty) begin
			if (pending_answers.size() == 0)
				report_mismatch("unexpected result", 1, 0);
			else begin
				want = pending_answers.pop_front();
				if (closest_distance !== want.distance)
					report_mismatch("closest_distance", closest_distance, want.distance);
				if (ray_param !== want.tpar)
					report_mismatch("ray_param", ray_param, want.tpar);
				if (parallel_flag !== want.par)
					report_mismatch("parallel_flag", parallel_flag, want.par);
				if (want.par) parallel_seen++;
				checked++;
			end
		end
	end

	function automatic logic signed [31:0] rnd_coord();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
			default: return $signed($urandom_range(0, 32'h07FF_FFFF)) - 32'sh0400_0000;
		endcase
	endfunction

	function automatic query_t rnd_query();
		query_t q;
		real vx, vy, vz, n;
		for (int k = 0; k < 3; k++) begin
			q.org[k] = rnd_coord();
			q.pa[k] = rnd_coord();
			q.pb[k] = $urandom_range(0, 7) == 0 ? q.pa[k] : rnd_coord();
		end
		if ($urandom_range(0, 5) == 0) begin
			for (int k = 0; k < 3; k++) q.dir[k] = $urandom;
		end else begin
			vx = $itor($signed($urandom_range(0, 2000))) - 1000.0;
			vy = $itor($signed($urandom_range(0, 2000))) - 1000.0;
			vz = $itor($signed($urandom_range(0, 2000))) - 1000.0;
			n = $sqrt(vx * vx + vy * vy + vz * vz) + 1.0e-3;
			q.dir[0] = $rtoi(vx / n * 65536.0);
			q.dir[1] = $rtoi(vy / n * 65536.0);
			q.dir[2] = $rtoi(vz / n * 65536.0);
		end
		// Segment parallel to the ray now and then.
		if ($urandom_range(0, 5) == 0)
			for (int k = 0; k < 3; k++) q.pb[k] = q.pa[k] + (q.dir[k] >>> 2);
		return q;
	endfunction

	task automatic wait_drained();
		push <= 1'b0;
		while (pending_answers.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	task automatic write_threshold(logic [31:0] v);
		cfg_wr_data <= v;
		cfg_wr_en <= 1'b1;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		threshold = v;
	endtask

	function automatic query_t mk(int ox, int oy, int oz, int dx, int dy, int dz,
		int ax, int ay, int az, int qx, int qy, int qz);
		query_t q;
		q.org = '{ox, oy, oz};
		q.dir = '{dx, dy, dz};
		q.pa = '{ax, ay, az};
		q.pb = '{qx, qy, qz};
		return q;
	endfunction

	task automatic test_directed();
		localparam int U = 65536;
		localparam int MX = 32'h7FFF_FFFF;
		localparam int MN = 32'h8000_0000;
		send_query(mk(0, 0, 0, U, 0, 0, 0, U, 0, 0, -U, 0), 1'b1);
		send_query(mk(0, 0, 0, U, 0, 0, U, U, 0, 2 * U, U, 0), 1'b1);
		send_query(mk(0, 0, 0, U, 0, 0, 5 * U, U, 3 * U, 5 * U, U, 3 * U), 1'b1);
		send_query(mk(0, 0, 0, U, 0, 0, -5 * U, 0, 0, -3 * U, 0, 0), 1'b1);
		send_query(mk(U, 2 * U, 3 * U, 0, 0, U, 2 * U, 0, U, 2 * U, 3 * U, U), 1'b1);
		send_query(mk(0, 0, 0, 3 * U, 0, 0, 0, U, 0, 0, -U, 0), 1'b1);
		send_query(mk(0, 0, 0, 0, U, 0, 4 * U, -U, 0, 4 * U, 8 * U, 0), 1'b1);
		send_query(mk(0, 0, 0, U, 0, 0, 0, 0, 0, 10 * U, 1, 0), 1'b1);
		send_query(mk(MX, MX, MX, MN, MN, MN, MN, MN, MN, MX, MX, MX), 1'b1);
		send_query(mk(MN, MN, MN, MX, MX, MX, MX, MX, MX, MN, MN, MN), 1'b1);
		send_query(mk(MX, MN, MX, U, 0, 0, MN, MX, MN, MN, MN, MX), 1'b1);
		send_query(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1);
		send_query(mk(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1), 1'b1);
		send_query(mk(MX, 0, 0, U, 0, 0, 0, MX, 0, 0, MN, 0), 1'b1);
		send_query(mk(0, 0, 0, 0, 0, U, 100, 200, 0, 100, 201, 3), 1'b1);
		wait_drained();
	endtask

	task automatic test_random(int n, bit gaps);
		for (int i = 0; i < n; i++) send_query(rnd_query(), gaps);
		wait_drained();
	endtask

	// Stops popping for a long time while items keep arriving, more than the
	// pipeline and queue can hold.
	task automatic test_backpressure();
		rx_hold = 300;
		for (int i = 0; i < 120; i++) send_query(rnd_query(), 1'b0);
		wait_drained();
	endtask

	initial begin
		threshold = 32'd43;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(60, 1'b1);
		write_threshold(32'd0);
		test_directed();
		test_random(40, 1'b1);
		write_threshold(32'hFFFF_FFFF);
		test_directed();
		test_random(40, 1'b1);
		write_threshold($urandom);
		test_random(40, 1'b1);
		test_backpressure();
		write_threshold(32'd43);
		rx_idle_on = 1'b0;
		test_random(60, 1'b0);
		$display("tb: %0d queries sent, %0d results checked, %0d parallel cases", sent, checked,
			parallel_seen);
		$display("tb: covered threshold extremes, degenerate segments and a long output stall");
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#5ms;
		$display("tb: failure");
		$finish;
	end
endmodule
